FILE: src/sum_checked_frame_builder_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the frame builder
// Concurrent checks on clk, quiet while rst is high; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef SUM_CHECKED_FRAME_BUILDER_CORE_MACROS_SVH
`define SUM_CHECKED_FRAME_BUILDER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Expression must hold on every clock edge out of reset.
`define SCFB_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("frame builder check failed");
// Same-cycle implication.
`define SCFB_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame builder check failed");
// Next-cycle implication.
`define SCFB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame builder check failed");
`else
`define SCFB_ASSERT_ALWAYS(lbl, expr)
`define SCFB_ASSERT_IMPL(lbl, ante, cons)
`define SCFB_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: src/scfb_pkg.sv
// ----------------------------------------------------------------------------
// scfb_pkg
// Shared constants and types for the framed byte stream builder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package scfb_pkg;

  localparam int unsigned MAX_LEN     = 65;
  localparam int unsigned MAX_RESULTS = 5;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int unsigned LEFT_W      = 7;
  localparam int unsigned LEN_W       = 16;
  localparam int unsigned BYTE_W      = 8;

  localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'hA1;

  typedef enum logic {
    OP_START = 1'b0,
    OP_DATA  = 1'b1
  } op_t;

  // Result bytes caused by one input transaction, oldest in slot 0.
  typedef struct packed {
    logic [CNT_W-1:0]                   cnt;
    logic [MAX_RESULTS-1:0][BYTE_W-1:0] bytes;
    logic                               term;  // final byte ends the frame
    logic                               err;   // single error result
  } burst_t;

endpackage

`default_nettype wire

FILE: src/scfb_if.sv
// ----------------------------------------------------------------------------
// scfb channel interfaces
// Valid/ready channels for input items and output stream bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface scfb_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [7:0]  command;
  logic [15:0] length;
  logic [7:0]  data_byte;

  modport source (output valid, op, command, length, data_byte, input ready);
  modport sink   (input valid, op, command, length, data_byte, output ready);
endinterface

interface scfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  logic       error;

  modport source (output valid, out_byte, last, error, input ready);
  modport sink   (input valid, out_byte, last, error, output ready);
endinterface

`default_nettype wire

FILE: src/scfb_frame_ctl.sv
// ----------------------------------------------------------------------------
// scfb_frame_ctl
// Input register, frame state and per-transaction result burst.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "sum_checked_frame_builder_core_macros.svh"

module scfb_frame_ctl (
  input  wire logic            clk,
  input  wire logic            rst,
  scfb_in_if.sink              in_ch,
  input  wire logic            can_take,
  output scfb_pkg::burst_t     burst,
  output logic                 burst_valid
);
  import scfb_pkg::*;

  logic                  v_q;
  logic                  op_q;
  logic [BYTE_W-1:0]     command_q;
  logic [LEN_W-1:0]      length_q;
  logic [BYTE_W-1:0]     data_q;

  logic                  in_frame, in_frame_next;
  logic [LEFT_W-1:0]     bytes_left, bytes_left_next;
  logic [BYTE_W-1:0]     running_sum, running_sum_next;

  logic                  take;
  logic                  len_ok;
  logic [BYTE_W-1:0]     hdr_sum;
  logic [LEFT_W-1:0]     start_left;
  logic [BYTE_W-1:0]     data_sum;
  logic [LEFT_W-1:0]     data_left;
  burst_t                b;

  assign take         = v_q && can_take;
  assign in_ch.ready  = !v_q || take;
  assign burst_valid  = take;
  assign burst        = b;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_q <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      v_q <= 1'b1;
    end else if (take) begin
      v_q <= 1'b0;
    end
    if (in_ch.valid && in_ch.ready) begin
      op_q      <= in_ch.op;
      command_q <= in_ch.command;
      length_q  <= in_ch.length;
      data_q    <= in_ch.data_byte;
    end
  end

  assign len_ok     = (length_q != '0) && (length_q <= LEN_W'(MAX_LEN));
  assign hdr_sum    = HEADER_BYTE + command_q + length_q[15:8] + length_q[7:0];
  assign start_left = length_q[LEFT_W-1:0] - LEFT_W'(1);
  assign data_sum   = running_sum + data_q;
  assign data_left  = bytes_left - LEFT_W'(1);

  always_comb begin
    b                = '0;
    in_frame_next    = in_frame;
    bytes_left_next  = bytes_left;
    running_sum_next = running_sum;
    case (op_t'(op_q))
      OP_START: begin
        if (!len_ok) begin
          b.cnt            = CNT_W'(1);
          b.term           = 1'b1;
          b.err            = 1'b1;
          in_frame_next    = 1'b0;
          bytes_left_next  = '0;
          running_sum_next = '0;
        end else begin
          b.bytes[0] = HEADER_BYTE;
          b.bytes[1] = command_q;
          b.bytes[2] = length_q[15:8];
          b.bytes[3] = length_q[7:0];
          if (start_left == '0) begin
            b.cnt            = CNT_W'(5);
            b.bytes[4]       = hdr_sum;
            b.term           = 1'b1;
            in_frame_next    = 1'b0;
            bytes_left_next  = '0;
            running_sum_next = '0;
          end else begin
            b.cnt            = CNT_W'(4);
            in_frame_next    = 1'b1;
            bytes_left_next  = start_left;
            running_sum_next = hdr_sum;
          end
        end
      end
      OP_DATA: begin
        if (!in_frame) begin
          b.cnt  = CNT_W'(1);
          b.term = 1'b1;
          b.err  = 1'b1;
        end else if (data_left == '0) begin
          b.cnt            = CNT_W'(2);
          b.bytes[0]       = data_q;
          b.bytes[1]       = data_sum;
          b.term           = 1'b1;
          in_frame_next    = 1'b0;
          bytes_left_next  = '0;
          running_sum_next = '0;
        end else begin
          b.cnt            = CNT_W'(1);
          b.bytes[0]       = data_q;
          bytes_left_next  = data_left;
          running_sum_next = data_sum;
        end
      end
      default: begin
        b.cnt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame    <= 1'b0;
      bytes_left  <= '0;
      running_sum <= '0;
    end else if (take) begin
      in_frame    <= in_frame_next;
      bytes_left  <= bytes_left_next;
      running_sum <= running_sum_next;
    end
  end

  // idle state is fully cleared
  `SCFB_ASSERT_IMPL(a_idle_clear, !in_frame, (bytes_left == '0) && (running_sum == '0))
  // an open frame always expects at least one more payload byte
  `SCFB_ASSERT_IMPL(a_open_left, in_frame, bytes_left != '0)
  // a held item with no room downstream stays held
  `SCFB_ASSERT_NEXT(a_hold, v_q && !can_take, v_q)

endmodule

`default_nettype wire

FILE: src/scfb_out_serializer.sv
// ----------------------------------------------------------------------------
// scfb_out_serializer
// Result buffer that drains a burst one byte per output transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "sum_checked_frame_builder_core_macros.svh"

module scfb_out_serializer (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire scfb_pkg::burst_t burst,
  input  wire logic            burst_valid,
  output logic                 can_take,
  scfb_out_if.source           out_ch
);
  import scfb_pkg::*;

  logic [CNT_W-1:0]                   cnt;
  logic [MAX_RESULTS-1:0][BYTE_W-1:0] buf_q;
  logic                               term;
  logic                               err;
  logic                               pop;

  assign pop      = (cnt != '0) && out_ch.ready;
  assign can_take = (cnt == '0) || ((cnt == CNT_W'(1)) && out_ch.ready);

  assign out_ch.valid    = cnt != '0;
  assign out_ch.out_byte = buf_q[0];
  assign out_ch.last     = term && (cnt == CNT_W'(1));
  assign out_ch.error    = err;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (burst_valid) begin
      cnt <= burst.cnt;
    end else if (pop) begin
      cnt <= cnt - CNT_W'(1);
    end
    if (burst_valid) begin
      buf_q <= burst.bytes;
      term  <= burst.term;
      err   <= burst.err;
    end else if (pop) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        buf_q[i] <= buf_q[i+1];
      end
    end
  end

  `SCFB_ASSERT_ALWAYS(a_cnt_range, cnt <= CNT_W'(MAX_RESULTS))
  // a new burst lands only once the old one is gone or leaving
  `SCFB_ASSERT_IMPL(a_no_overwrite, burst_valid, can_take)
  // an error result is always a lone, final byte
  `SCFB_ASSERT_IMPL(a_err_last, out_ch.valid && out_ch.error, out_ch.last)

endmodule

`default_nettype wire

FILE: src/sum_checked_frame_builder_core.sv
// ----------------------------------------------------------------------------
// sum_checked_frame_builder_core
// Framed byte stream builder with 8-bit additive checksum.
// ----------------------------------------------------------------------------
// Each input transaction is captured in an input register, turned into a burst
// of stream bytes in one pass of short logic, and placed in a five-byte result
// buffer that feeds the output channel one byte per transaction. A data item
// gives one output byte, or two when it closes the frame (payload plus
// checksum); a start item gives four bytes (0xA1, command, length high, length
// low) or five when length is 1 and the checksum follows the header at once.
// The pace is set by the single-byte output port draining that buffer: a new
// item moves into the buffer in the same cycle its last pending byte is taken,
// so payload bytes run at one per cycle while ready is high. A bad length (0 or
// above 65) or a data item with no open frame gives one byte 0 with last and
// error set. A start item during an open frame drops that frame without a checksum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sum_checked_frame_builder_core (
  input  wire logic clk,
  input  wire logic rst,
  scfb_in_if.sink   in_ch,
  scfb_out_if.source out_ch
);
  import scfb_pkg::*;

  burst_t burst;
  logic   burst_valid;
  logic   can_take;

  // input register, frame state, burst build
  scfb_frame_ctl u_ctl (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .can_take    (can_take),
    .burst       (burst),
    .burst_valid (burst_valid)
  );

  // result buffer, one byte per output transaction
  scfb_out_serializer u_ser (
    .clk         (clk),
    .rst         (rst),
    .burst       (burst),
    .burst_valid (burst_valid),
    .can_take    (can_take),
    .out_ch      (out_ch)
  );

endmodule

`default_nettype wire
